@@ rtl/core/rids_pkg.sv @@
// ----------------------------------------------------------------------------
// rids_pkg: shared types and constants of the rom id search unit
// Request codes, default sizes and the result flag group passed from the
// decision logic to the top level.
// ----------------------------------------------------------------------------
package rids_pkg;

  // default number of id bits searched per pass
  localparam int unsigned IdBitsDefault = 64;

  // positions below this limit lie inside the family byte
  localparam int unsigned FamilyLimit = 9;

  // width of the fixed rom id field on the ports
  localparam int unsigned RomIdWidth = 64;

  // width of the family discrepancy field
  localparam int unsigned FamDiscWidth = 4;

  // request codes
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_TARGET = 2'd1,
    REQ_BEGIN  = 2'd2,
    REQ_PAIR   = 2'd3
  } req_code_t;

  // per-request flags produced by the decision logic
  typedef struct packed {
    logic write_bit;
    logic write_valid;
    logic pass_done;
    logic found;
  } step_flags_t;

endpackage

@@ rtl/core/rids_step.sv @@
// ----------------------------------------------------------------------------
// rids_step: search decision logic for one request
// Computes the next search state and the result flags from the current
// state and one registered request. Purely combinational.
// ----------------------------------------------------------------------------
module rids_step #(
  parameter int unsigned ID_BITS = rids_pkg::IdBitsDefault,
  parameter int unsigned POS_W   = $clog2(ID_BITS + 2)
) (
  input  rids_pkg::req_code_t                  req,
  input  logic                                 presence,
  input  logic                                 id_bit,
  input  logic                                 cmp_bit,
  input  logic [7:0]                           family_seed,
  input  logic [ID_BITS-1:0]                   id_reg,
  input  logic [POS_W-1:0]                     last_disc,
  input  logic [rids_pkg::FamDiscWidth-1:0]    fam_disc,
  input  logic                                 last_dev,
  input  logic [POS_W-1:0]                     bit_pos,
  input  logic [POS_W-1:0]                     zero_choice,
  input  logic                                 pass_active,
  output logic [ID_BITS-1:0]                   id_reg_next,
  output logic [POS_W-1:0]                     last_disc_next,
  output logic [rids_pkg::FamDiscWidth-1:0]    fam_disc_next,
  output logic                                 last_dev_next,
  output logic [POS_W-1:0]                     bit_pos_next,
  output logic [POS_W-1:0]                     zero_choice_next,
  output logic                                 pass_active_next,
  output rids_pkg::step_flags_t                flags
);

  localparam int unsigned IDX_W = $clog2(ID_BITS);
  localparam logic [POS_W-1:0] PosLast   = POS_W'(ID_BITS);
  localparam logic [POS_W-1:0] PosFamLim = POS_W'(rids_pkg::FamilyLimit);
  localparam logic [POS_W-1:0] PosOne    = POS_W'(1);

  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] idx;
  logic             dir;
  logic [POS_W-1:0] zero_pos;

  // current bit position, forced into range
  always_comb begin
    if (bit_pos == '0 || bit_pos > PosLast) begin
      pos = PosOne;
    end else begin
      pos = bit_pos;
    end
    idx = IDX_W'(pos - PosOne);
  end

  // search direction for a pair that is not all ones
  always_comb begin
    if (id_bit != cmp_bit) begin
      dir = id_bit;
    end else if (pos < last_disc) begin
      dir = id_reg[idx];
    end else begin
      dir = (pos == last_disc);
    end
    if (id_bit == cmp_bit && !dir) begin
      zero_pos = pos;
    end else begin
      zero_pos = zero_choice;
    end
  end

  // next state and flags
  always_comb begin
    id_reg_next      = id_reg;
    last_disc_next   = last_disc;
    fam_disc_next    = fam_disc;
    last_dev_next    = last_dev;
    bit_pos_next     = bit_pos;
    zero_choice_next = zero_choice;
    pass_active_next = pass_active;
    flags            = '0;
    case (req)
      rids_pkg::REQ_CLEAR: begin
        id_reg_next      = '0;
        last_disc_next   = '0;
        fam_disc_next    = '0;
        last_dev_next    = 1'b0;
        pass_active_next = 1'b0;
      end
      rids_pkg::REQ_TARGET: begin
        id_reg_next      = ID_BITS'(family_seed);
        last_disc_next   = PosLast;
        fam_disc_next    = '0;
        last_dev_next    = 1'b0;
        pass_active_next = 1'b0;
      end
      rids_pkg::REQ_BEGIN: begin
        bit_pos_next     = PosOne;
        zero_choice_next = '0;
        if (last_dev || !presence) begin
          last_disc_next   = '0;
          fam_disc_next    = '0;
          last_dev_next    = 1'b0;
          pass_active_next = 1'b0;
          flags.pass_done  = 1'b1;
        end else begin
          pass_active_next = 1'b1;
        end
      end
      rids_pkg::REQ_PAIR: begin
        if (pass_active) begin
          if (id_bit && cmp_bit) begin
            // no device answered: abort the pass
            last_disc_next   = '0;
            fam_disc_next    = '0;
            last_dev_next    = 1'b0;
            pass_active_next = 1'b0;
            flags.pass_done  = 1'b1;
          end else begin
            id_reg_next[idx]  = dir;
            zero_choice_next  = zero_pos;
            if (id_bit == cmp_bit && !dir && pos < PosFamLim) begin
              fam_disc_next = rids_pkg::FamDiscWidth'(pos);
            end
            flags.write_bit   = dir;
            flags.write_valid = 1'b1;
            bit_pos_next      = pos + PosOne;
            if (pos == PosLast) begin
              // last bit decided: close the pass
              flags.pass_done  = 1'b1;
              flags.found      = 1'b1;
              pass_active_next = 1'b0;
              last_disc_next   = zero_pos;
              if (zero_pos == '0) begin
                last_dev_next = 1'b1;
              end
              if (id_reg_next[7:0] == 8'd0) begin
                last_disc_next = '0;
                fam_disc_next  = '0;
                last_dev_next  = 1'b0;
                flags.found    = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        flags = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/rom_id_search_unit.sv @@
// ----------------------------------------------------------------------------
// rom_id_search_unit: decision core of the bus rom search
// Keeps the search state across passes and turns each request into the
// direction bit to write, the pass status and the current id.
// ----------------------------------------------------------------------------
//
//  channel   | valid / stall        | payload
//  ----------+----------------------+------------------------------------------
//  request   | req_valid/req_stall  | req_type presence id_bit cmp_bit
//            |                      | family_seed
//  result    | res_valid/res_stall  | write_bit write_valid pass_done found
//            |                      | last_device rom_id family_discrepancy
//
//  one request per cycle sustained while res_stall is low; a taken request
//  is held in the request register, then moves into the result register.
//  the search state is updated in the cycle a request moves into the result
//  register, so each request sees the state left by the one before it.
//  res_stall holds the result register; the request register then fills and
//  req_stall rises. synchronous reset clears the search state and both
//  stages.
//
module rom_id_search_unit #(
  parameter int unsigned ID_BITS = rids_pkg::IdBitsDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic [1:0]                         req_type,
  input  logic                               presence,
  input  logic                               id_bit,
  input  logic                               cmp_bit,
  input  logic [7:0]                         family_seed,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic                               write_bit,
  output logic                               write_valid,
  output logic                               pass_done,
  output logic                               found,
  output logic                               last_device,
  output logic [rids_pkg::RomIdWidth-1:0]    rom_id,
  output logic [rids_pkg::FamDiscWidth-1:0]  family_discrepancy
);

  localparam int unsigned POS_W = $clog2(ID_BITS + 2);

  // request register
  logic                 rq_valid;
  rids_pkg::req_code_t  rq_type;
  logic                 rq_presence;
  logic                 rq_id_bit;
  logic                 rq_cmp_bit;
  logic [7:0]           rq_family;

  // search state
  logic [ID_BITS-1:0]                 id_reg;
  logic [POS_W-1:0]                   last_disc;
  logic [rids_pkg::FamDiscWidth-1:0]  fam_disc;
  logic                               last_dev;
  logic [POS_W-1:0]                   bit_pos;
  logic [POS_W-1:0]                   zero_choice;
  logic                               pass_active;

  logic [ID_BITS-1:0]                 id_reg_next;
  logic [POS_W-1:0]                   last_disc_next;
  logic [rids_pkg::FamDiscWidth-1:0]  fam_disc_next;
  logic                               last_dev_next;
  logic [POS_W-1:0]                   bit_pos_next;
  logic [POS_W-1:0]                   zero_choice_next;
  logic                               pass_active_next;
  rids_pkg::step_flags_t              flags;

  logic res_free;
  logic advance;
  logic take;

  // handshake between the two stages
  assign res_free  = !res_valid || !res_stall;
  assign advance   = rq_valid && res_free;
  assign req_stall = rq_valid && !res_free;
  assign take      = req_valid && !req_stall;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_valid <= 1'b0;
    end else if (take) begin
      rq_valid <= 1'b1;
    end else if (advance) begin
      rq_valid <= 1'b0;
    end
    if (take) begin
      rq_type     <= rids_pkg::req_code_t'(req_type);
      rq_presence <= presence;
      rq_id_bit   <= id_bit;
      rq_cmp_bit  <= cmp_bit;
      rq_family   <= family_seed;
    end
  end

  // decision logic
  rids_step #(
    .ID_BITS (ID_BITS),
    .POS_W   (POS_W)
  ) u_step (
    .req              (rq_type),
    .presence         (rq_presence),
    .id_bit           (rq_id_bit),
    .cmp_bit          (rq_cmp_bit),
    .family_seed      (rq_family),
    .id_reg           (id_reg),
    .last_disc        (last_disc),
    .fam_disc         (fam_disc),
    .last_dev         (last_dev),
    .bit_pos          (bit_pos),
    .zero_choice      (zero_choice),
    .pass_active      (pass_active),
    .id_reg_next      (id_reg_next),
    .last_disc_next   (last_disc_next),
    .fam_disc_next    (fam_disc_next),
    .last_dev_next    (last_dev_next),
    .bit_pos_next     (bit_pos_next),
    .zero_choice_next (zero_choice_next),
    .pass_active_next (pass_active_next),
    .flags            (flags)
  );

  // search state update
  always_ff @(posedge clk) begin
    if (rst) begin
      id_reg      <= '0;
      last_disc   <= '0;
      fam_disc    <= '0;
      last_dev    <= 1'b0;
      bit_pos     <= POS_W'(1);
      zero_choice <= '0;
      pass_active <= 1'b0;
    end else if (advance) begin
      id_reg      <= id_reg_next;
      last_disc   <= last_disc_next;
      fam_disc    <= fam_disc_next;
      last_dev    <= last_dev_next;
      bit_pos     <= bit_pos_next;
      zero_choice <= zero_choice_next;
      pass_active <= pass_active_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (advance) begin
      write_bit          <= flags.write_bit;
      write_valid        <= flags.write_valid;
      pass_done          <= flags.pass_done;
      found              <= flags.found;
      last_device        <= last_dev_next;
      rom_id             <= rids_pkg::RomIdWidth'(id_reg_next);
      family_discrepancy <= fam_disc_next;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the rom id search unit
// Drives search requests through the valid/stall request channel and checks
// every result against a local model of the search state. A short table of
// hand-picked requests comes first, then random searches over simulated bus
// populations, random passes and random noise, with random idling and
// stalling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned IdBits     = rids_pkg::IdBitsDefault;
  localparam logic [63:0] IdMask     = (IdBits >= 64) ? '1 : ((64'd1 << IdBits) - 64'd1);
  localparam int          ItemTarget = 1850;
  localparam int          IdlePct    = 11;
  localparam int          CycleLimit = 400000;

  typedef struct packed {
    rids_pkg::req_code_t kind;
    logic                presence;
    logic                id_bit;
    logic                cmp_bit;
    logic [7:0]          family_seed;
  } search_req_t;

  typedef struct packed {
    logic        write_bit;
    logic        write_valid;
    logic        pass_done;
    logic        found;
    logic        last_device;
    logic [63:0] rom_id;
    logic [3:0]  family_discrepancy;
  } search_res_t;

  typedef struct packed {
    search_req_t req;
    logic        typed;
    search_res_t want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  req_type = '0;
  logic        presence = 1'b0;
  logic        id_bit = 1'b0;
  logic        cmp_bit = 1'b0;
  logic [7:0]  family_seed = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        write_bit;
  logic        write_valid;
  logic        pass_done;
  logic        found;
  logic        last_device;
  logic [63:0] rom_id;
  logic [3:0]  family_discrepancy;

  // model of the search state
  logic [63:0] srch_id;
  logic [6:0]  srch_last_disc;
  logic [3:0]  srch_fam_disc;
  logic        srch_last_dev;
  logic [6:0]  srch_pos;
  logic [6:0]  srch_zero_pos;
  logic        srch_active;

  search_res_t pending_res[$];
  int          n_errors = 0;
  int          n_items = 0;
  int          n_cycles = 0;
  logic        quiet;

  // long stretch with no idling on either side
  assign quiet = (n_items >= 700) && (n_items < 1000);

  always #5 clk = ~clk;

  rom_id_search_unit i_dut (
    .clk                (clk),
    .rst                (rst),
    .req_valid          (req_valid),
    .req_stall          (req_stall),
    .req_type           (req_type),
    .presence           (presence),
    .id_bit             (id_bit),
    .cmp_bit            (cmp_bit),
    .family_seed        (family_seed),
    .res_valid          (res_valid),
    .res_stall          (res_stall),
    .write_bit          (write_bit),
    .write_valid        (write_valid),
    .pass_done          (pass_done),
    .found              (found),
    .last_device        (last_device),
    .rom_id             (rom_id),
    .family_discrepancy (family_discrepancy)
  );

  // discrepancies and last-device flag back to a fresh search
  function automatic void forget_search();
    srch_last_disc = '0;
    srch_last_dev  = 1'b0;
    srch_fam_disc  = '0;
  endfunction

  function automatic void reset_search();
    srch_id       = '0;
    forget_search();
    srch_pos      = 7'd1;
    srch_zero_pos = '0;
    srch_active   = 1'b0;
  endfunction

  // apply one request to the search state and return its result
  function automatic search_res_t search_step(search_req_t r);
    search_res_t o;
    logic [6:0]  pos;
    logic        dir;
    logic [63:0] bm;
    o = '0;
    case (r.kind)
      rids_pkg::REQ_CLEAR: begin
        srch_id = '0;
        forget_search();
        srch_active = 1'b0;
      end
      rids_pkg::REQ_TARGET: begin
        srch_id        = {56'd0, r.family_seed} & IdMask;
        srch_last_disc = 7'(IdBits);
        srch_fam_disc  = '0;
        srch_last_dev  = 1'b0;
        srch_active    = 1'b0;
      end
      rids_pkg::REQ_BEGIN: begin
        srch_pos      = 7'd1;
        srch_zero_pos = '0;
        if (srch_last_dev || !r.presence) begin
          forget_search();
          srch_active = 1'b0;
          o.pass_done = 1'b1;
        end else begin
          srch_active = 1'b1;
        end
      end
      default: begin
        if (srch_active) begin
          if (r.id_bit && r.cmp_bit) begin
            // nobody answered: abort the pass
            forget_search();
            srch_active = 1'b0;
            o.pass_done = 1'b1;
          end else begin
            pos = srch_pos;
            if (pos < 7'd1 || pos > IdBits) pos = 7'd1;
            bm = 64'd1 << (pos - 7'd1);
            if (r.id_bit != r.cmp_bit) begin
              dir = r.id_bit;
            end else begin
              // discrepancy: follow the previous path, turn at the last one
              if (pos < srch_last_disc) dir = |(srch_id & bm);
              else dir = (pos == srch_last_disc);
              if (!dir) begin
                srch_zero_pos = pos;
                if (pos < rids_pkg::FamilyLimit) srch_fam_disc = pos[3:0];
              end
            end
            if (dir) srch_id = srch_id | bm;
            else srch_id = srch_id & ~bm;
            o.write_bit   = dir;
            o.write_valid = 1'b1;
            srch_pos = pos + 7'd1;
            if (srch_pos > IdBits) begin
              o.pass_done    = 1'b1;
              o.found        = 1'b1;
              srch_active    = 1'b0;
              srch_last_disc = srch_zero_pos;
              if (srch_last_disc == 0) srch_last_dev = 1'b1;
              if (srch_id[7:0] == 8'd0) begin
                forget_search();
                o.found = 1'b0;
              end
            end
          end
        end
      end
    endcase
    o.last_device        = srch_last_dev;
    o.rom_id             = srch_id;
    o.family_discrepancy = srch_fam_disc;
    return o;
  endfunction

  function automatic search_req_t mk_req(rids_pkg::req_code_t kind, logic p, logic ib,
                                         logic cb, logic [7:0] fam);
    return {kind, p, ib, cb, fam};
  endfunction

  function automatic search_res_t mk_res(logic wb, logic wv, logic pd, logic fnd, logic ld,
                                         logic [63:0] id, logic [3:0] fd);
    return {wb, wv, pd, fnd, ld, id, fd};
  endfunction

  // request of the given kind with every other field random
  function automatic search_req_t rand_request(rids_pkg::req_code_t kind);
    search_req_t r;
    r.kind        = kind;
    r.presence    = 1'($urandom_range(1));
    r.id_bit      = 1'($urandom_range(1));
    r.cmp_bit     = 1'($urandom_range(1));
    r.family_seed = 8'($urandom_range(255));
    return r;
  endfunction

  // send one request; the predicted result comes back in got
  task automatic push_request(output search_res_t got, input search_req_t r,
                              input logic use_typed, input search_res_t typed_want);
    n_items++;
    got = search_step(r);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= r.kind;
    presence    <= r.presence;
    id_bit      <= r.id_bit;
    cmp_bit     <= r.cmp_bit;
    family_seed <= r.family_seed;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_res.push_back(use_typed ? typed_want : got);
  endtask

  // hold off new requests until every result is back
  task automatic drain_results();
    if (req_valid) req_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // random stall on the result side
  always @(posedge clk) begin
    res_stall <= !quiet && ($urandom_range(99) < IdlePct);
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin : result_check
    search_res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_res.size() == 0) begin
        $error("result with no request pending");
        n_errors++;
      end else begin
        want = pending_res.pop_front();
        check_field("write_bit", 64'(want.write_bit), 64'(write_bit));
        check_field("write_valid", 64'(want.write_valid), 64'(write_valid));
        check_field("pass_done", 64'(want.pass_done), 64'(pass_done));
        check_field("found", 64'(want.found), 64'(found));
        check_field("last_device", 64'(want.last_device), 64'(last_device));
        check_field("rom_id", want.rom_id, rom_id);
        check_field("family_discrepancy", 64'(want.family_discrepancy),
                    64'(family_discrepancy));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    table_row_t  dir_tab[$];
    search_req_t rq;
    search_res_t res;
    logic [63:0] dev_id [4];
    logic [3:0]  dev_on;
    logic [63:0] keep;
    logic        ib;
    logic        cb;
    logic        stop;
    int          n_dev;
    int          passes;
    int          sel;
    int          k;
    int          d;

    reset_search();

    // hand-picked requests; typed rows carry their result, the rest use the model
    dir_tab.push_back({mk_req(rids_pkg::REQ_PAIR, 1'b0, 1'b1, 1'b0, 8'h00), 1'b1,
                       mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_BEGIN, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
                       mk_res(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 64'h0, 4'd0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_TARGET, 1'b1, 1'b1, 1'b1, 8'hFF), 1'b1,
                       mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'hFF, 4'd0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_TARGET, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
                       mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_CLEAR, 1'b1, 1'b1, 1'b1, 8'hFF), 1'b1,
                       mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_BEGIN, 1'b1, 1'b0, 1'b0, 8'h00), 1'b1,
                       mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0, 4'd0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_PAIR, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
                       mk_res(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 64'h0, 4'd1)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_PAIR, 1'b0, 1'b1, 1'b0, 8'h00), 1'b1,
                       mk_res(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 64'h2, 4'd1)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_PAIR, 1'b0, 1'b0, 1'b1, 8'h00), 1'b1,
                       mk_res(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 64'h2, 4'd1)});
    // both bits one aborts the pass
    dir_tab.push_back({mk_req(rids_pkg::REQ_PAIR, 1'b0, 1'b1, 1'b1, 8'h00), 1'b1,
                       mk_res(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 64'h2, 4'd0)});
    // pair outside a pass is ignored
    dir_tab.push_back({mk_req(rids_pkg::REQ_PAIR, 1'b1, 1'b0, 1'b0, 8'hFF), 1'b1,
                       mk_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 64'h2, 4'd0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_BEGIN, 1'b1, 1'b1, 1'b1, 8'h80), 1'b0,
                       search_res_t'('0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_PAIR, 1'b0, 1'b0, 1'b0, 8'h01), 1'b0,
                       search_res_t'('0)});
    // begin during a pass restarts it
    dir_tab.push_back({mk_req(rids_pkg::REQ_BEGIN, 1'b1, 1'b0, 1'b0, 8'h00), 1'b0,
                       search_res_t'('0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_PAIR, 1'b1, 1'b1, 1'b0, 8'h80), 1'b0,
                       search_res_t'('0)});
    // targeted search drops the open pass
    dir_tab.push_back({mk_req(rids_pkg::REQ_TARGET, 1'b0, 1'b0, 1'b0, 8'hA5), 1'b0,
                       search_res_t'('0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_PAIR, 1'b0, 1'b0, 1'b0, 8'h00), 1'b0,
                       search_res_t'('0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_BEGIN, 1'b1, 1'b0, 1'b0, 8'h01), 1'b0,
                       search_res_t'('0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_PAIR, 1'b1, 1'b0, 1'b0, 8'h00), 1'b0,
                       search_res_t'('0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_PAIR, 1'b0, 1'b0, 1'b0, 8'h7F), 1'b0,
                       search_res_t'('0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_CLEAR, 1'b0, 1'b0, 1'b0, 8'h00), 1'b0,
                       search_res_t'('0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_PAIR, 1'b0, 1'b1, 1'b1, 8'h00), 1'b0,
                       search_res_t'('0)});
    dir_tab.push_back({mk_req(rids_pkg::REQ_BEGIN, 1'b0, 1'b1, 1'b0, 8'hFE), 1'b0,
                       search_res_t'('0)});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) push_request(res, dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
    drain_results();

    while (n_items < ItemTarget) begin
      sel = $urandom_range(99);
      if (sel < 50) begin
        // full search over a simulated device population
        n_dev = $urandom_range(4);
        for (d = 0; d < 4; d++) begin
          dev_id[d] = {32'($urandom), 32'($urandom)};
          if ($urandom_range(1) == 0 && d > 0) begin
            // share a prefix with the first device for deep discrepancies
            keep = (64'd1 << $urandom_range(1, 63)) - 64'd1;
            dev_id[d] = (dev_id[0] & keep) | (dev_id[d] & ~keep);
          end
          if ($urandom_range(5) == 0) dev_id[d][7:0] = 8'd0;
        end
        if ($urandom_range(3) == 0) begin
          rq = rand_request(rids_pkg::REQ_TARGET);
          if ($urandom_range(1) == 0) rq.family_seed = dev_id[0][7:0];
        end else begin
          rq = rand_request(rids_pkg::REQ_CLEAR);
        end
        push_request(res, rq, 1'b0, '0);
        stop   = 1'b0;
        passes = 0;
        while (!stop && passes < n_dev + 3 && n_items < ItemTarget) begin
          passes++;
          rq = rand_request(rids_pkg::REQ_BEGIN);
          rq.presence = (n_dev > 0);
          if ($urandom_range(19) == 0) rq.presence = ~rq.presence;
          push_request(res, rq, 1'b0, '0);
          if (res.pass_done) begin
            stop = 1'b1;
          end else begin
            dev_on = '0;
            for (d = 0; d < n_dev; d++) dev_on[d] = 1'b1;
            for (k = 0; k < 64 && srch_active; k++) begin
              // wired-and of every device still taking part
              ib = 1'b1;
              cb = 1'b1;
              for (d = 0; d < 4; d++) begin
                if (dev_on[d]) begin
                  ib = ib & dev_id[d][k];
                  cb = cb & ~dev_id[d][k];
                end
              end
              rq = rand_request(rids_pkg::REQ_PAIR);
              rq.id_bit  = ib;
              rq.cmp_bit = cb;
              push_request(res, rq, 1'b0, '0);
              for (d = 0; d < 4; d++) begin
                if (dev_on[d] && dev_id[d][k] != res.write_bit) dev_on[d] = 1'b0;
              end
            end
          end
        end
      end else if (sel < 80) begin
        // pass with random bit pairs and a little noise
        rq = rand_request(rids_pkg::REQ_BEGIN);
        rq.presence = ($urandom_range(9) != 0);
        push_request(res, rq, 1'b0, '0);
        k = 0;
        while (srch_active && k < 80) begin
          if ($urandom_range(99) == 0) begin
            rq = rand_request(rids_pkg::req_code_t'($urandom_range(3)));
          end else begin
            rq = rand_request(rids_pkg::REQ_PAIR);
            if (rq.id_bit && rq.cmp_bit && $urandom_range(39) != 0) rq.cmp_bit = 1'b0;
          end
          push_request(res, rq, 1'b0, '0);
          k++;
        end
      end else begin
        // short burst of arbitrary requests
        for (k = $urandom_range(1, 6); k > 0; k--) begin
          push_request(res, rand_request(rids_pkg::req_code_t'($urandom_range(3))),
                       1'b0, '0);
        end
      end
      if ($urandom_range(11) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (n_errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
